>>> hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] COLOR_RESET = 8'd10;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic exec;
    logic copy_rd;
    logic copy_wr;
    logic fill;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_clear;
    logic start_scroll;
    logic end_copy;
    logic end_fill;
  } status_t;

endpackage

>>> hw/rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  tcw_pkg::state_t state_r;
  tcw_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != tcw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.exec = 1'b1;
          if (status.start_clear) begin
            state_nxt = tcw_pkg::ST_FILL;
          end else if (status.start_scroll) begin
            state_nxt = tcw_pkg::ST_COPY_RD;
          end else begin
            state_nxt = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = tcw_pkg::ST_COPY_WR;
      end
      tcw_pkg::ST_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (status.end_copy) begin
          state_nxt = tcw_pkg::ST_FILL;
        end else begin
          state_nxt = tcw_pkg::ST_COPY_RD;
        end
      end
      tcw_pkg::ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.end_fill) begin
          state_nxt = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

>>> hw/rtl/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  tcw_pkg::cmd_t      cmd,
  output tcw_pkg::status_t   status,
  output tcw_pkg::out_item_t out_data
);

  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = 1 << AW;

  logic [15:0] mem [MEM_DEPTH];

  logic [7:0]    color_r;
  logic [RW-1:0] cur_row_r;
  logic [RW-1:0] cur_row_nxt;
  logic [CW-1:0] cur_col_r;
  logic [CW-1:0] cur_col_nxt;
  logic [RW-1:0] walk_row_r;
  logic [RW-1:0] walk_row_nxt;
  logic [CW-1:0] walk_col_r;
  logic [CW-1:0] walk_col_nxt;
  logic [15:0]   rdata_r;
  logic          res_read_r;
  logic          res_scroll_r;
  tcw_pkg::out_item_t out_data_r;

  logic          is_put;
  logic          is_read;
  logic          is_nl;
  logic          is_cr;
  logic          is_bs;
  logic          is_norm;
  logic          row_last;
  logic          col_last;
  logic          col_zero;
  logic          row_adv;
  logic          read_ok;
  logic          walk_col_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  assign is_put   = (in_data.opcode == tcw_pkg::OP_PUT);
  assign is_read  = (in_data.opcode == tcw_pkg::OP_READ);
  assign is_nl    = (in_data.char_code == tcw_pkg::CH_NEWLINE);
  assign is_cr    = (in_data.char_code == tcw_pkg::CH_RETURN);
  assign is_bs    = (in_data.char_code == tcw_pkg::CH_BACKSPACE);
  assign is_norm  = !is_nl && !is_cr && !is_bs;
  assign row_last = (cur_row_r == RW'(ROWS - 1));
  assign col_last = (cur_col_r == CW'(COLUMNS - 1));
  assign col_zero = (cur_col_r == '0);
  assign row_adv  = is_put && (is_nl || (is_norm && col_last));
  assign read_ok  = is_read && ({4'd0, in_data.read_row} < 9'(ROWS))
                  && ({2'd0, in_data.read_col} < 9'(COLUMNS));

  assign walk_col_last = (walk_col_r == CW'(COLUMNS - 1));

  assign status.start_clear  = (in_data.opcode == tcw_pkg::OP_CLEAR);
  assign status.start_scroll = row_adv && row_last;
  assign status.end_copy     = (walk_row_r == RW'(ROWS - 2)) && walk_col_last;
  assign status.end_fill     = (walk_row_r == RW'(ROWS - 1)) && walk_col_last;

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (cmd.exec) begin
      if (status.start_clear) begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end else if (is_put) begin
        priority if (is_nl || is_cr) begin
          cur_col_nxt = '0;
        end else if (is_bs) begin
          if (!col_zero) begin
            cur_col_nxt = cur_col_r - 1'b1;
          end
        end else begin
          cur_col_nxt = col_last ? '0 : cur_col_r + 1'b1;
        end
        if (row_adv && !row_last) begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    walk_row_nxt = walk_row_r;
    walk_col_nxt = walk_col_r;
    if (cmd.exec) begin
      walk_row_nxt = '0;
      walk_col_nxt = '0;
    end else if (cmd.copy_wr || cmd.fill) begin
      if (walk_col_last) begin
        walk_col_nxt = '0;
        walk_row_nxt = walk_row_r + 1'b1;
      end else begin
        walk_col_nxt = walk_col_r + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {walk_row_r, walk_col_r};
    mem_wdata = {color_r, tcw_pkg::CH_BLANK};
    if (cmd.exec) begin
      mem_we    = is_put && (is_norm || (is_bs && !col_zero));
      mem_waddr = {cur_row_r, is_bs ? cur_col_r - 1'b1 : cur_col_r};
      mem_wdata = {color_r, is_bs ? tcw_pkg::CH_BLANK : in_data.char_code};
    end else if (cmd.copy_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r;
    end else if (cmd.fill) begin
      mem_we    = 1'b1;
    end
  end

  always_comb begin
    mem_re    = cmd.copy_rd || (cmd.exec && read_ok);
    mem_raddr = {walk_row_r + 1'b1, walk_col_r};
    if (cmd.exec) begin
      mem_raddr = {RW'(in_data.read_row), CW'(in_data.read_col)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r    <= tcw_pkg::COLOR_RESET;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      walk_row_r <= '0;
      walk_col_r <= '0;
    end else begin
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      walk_row_r <= walk_row_nxt;
      walk_col_r <= walk_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_read_r   <= read_ok;
      res_scroll_r <= status.start_scroll;
    end
    if (cmd.load_out) begin
      out_data_r.cursor_row_out <= 5'(cur_row_r);
      out_data_r.cursor_col_out <= 7'(cur_col_r);
      out_data_r.cell_char      <= res_read_r ? rdata_r[7:0] : 8'd0;
      out_data_r.cell_color     <= res_read_r ? rdata_r[15:8] : 8'd0;
      out_data_r.scrolled       <= res_scroll_r;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> hw/rtl/text_console_writer_unit.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   tcw_pkg::in_item_t
// out_     output     out_valid/out_stall tcw_pkg::out_item_t
// cfg_     input      cfg_we              cfg_wdata (text color)
//
// Put, read and unused opcodes go from the accept state straight to the result register load.
// Clear writes one blank cell per cycle over the whole grid.
// A put that scrolls moves each cell of the cell store up a row, with a read state and then
// a write state per cell, and then blanks the bottom row.
// Reset homes the cursor and sets the color; the cell store is not cleared.
// A stalled result still lets the next transaction in, which then keeps the input stalled
// until the waiting result is taken and its own result is loaded.
module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/tcw_checker.sv
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tcw_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_stall
);

  // Only one transaction is in flight at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({4'd0, out_data.cursor_row_out} < 9'(ROWS))
               && ({2'd0, out_data.cursor_col_out} < 9'(COLUMNS)))
    else $error("cursor outside the grid");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      (out_data.cursor_col_out == 7'd0) && (out_data.cursor_row_out == 5'(ROWS - 1)))
    else $error("scroll left the cursor off the start of the bottom row");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

>>> test/text_console_checker.sv
`timescale 1ns / 1ps
module text_console_checker #(
  parameter int COLS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tcw_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tcw_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output int                  n_pending,
  output int                  n_results,
  output int                  n_scrolls,
  output int                  n_fail
);

  logic [15:0]        screen [ROWS*COLS];
  int                 cur_row;
  int                 cur_col;
  logic [7:0]         ink;
  tcw_pkg::out_item_t due_results [$];
  int                 fails;
  int                 checked;
  int                 scrolls;

  function automatic tcw_pkg::out_item_t console_step(input tcw_pkg::in_item_t it);
    tcw_pkg::out_item_t r;
    int row;
    int col;
    int i;
    r = '0;
    row = cur_row;
    col = cur_col;
    unique case (it.opcode)
      tcw_pkg::OP_PUT: begin
        if (it.char_code == tcw_pkg::CH_NEWLINE) begin
          col = 0;
          row++;
        end else if (it.char_code == tcw_pkg::CH_RETURN) begin
          col = 0;
        end else if (it.char_code == tcw_pkg::CH_BACKSPACE) begin
          if (col > 0) begin
            col--;
            screen[row*COLS + col] = {ink, tcw_pkg::CH_BLANK};
          end
        end else begin
          screen[row*COLS + col] = {ink, it.char_code};
          col++;
          if (col >= COLS) begin
            col = 0;
            row++;
          end
        end
        if (row >= ROWS) begin
          for (i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i + COLS];
          for (i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen[i] = {ink, tcw_pkg::CH_BLANK};
          row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (i = 0; i < ROWS*COLS; i++) screen[i] = {ink, tcw_pkg::CH_BLANK};
        row = 0;
        col = 0;
      end
      tcw_pkg::OP_READ: begin
        if (int'(it.read_row) < ROWS && int'(it.read_col) < COLS) begin
          {r.cell_color, r.cell_char} = screen[int'(it.read_row)*COLS + int'(it.read_col)];
        end
      end
      default: begin
      end
    endcase
    cur_row = row;
    cur_col = col;
    r.cursor_row_out = row[4:0];
    r.cursor_col_out = col[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    tcw_pkg::out_item_t want;
    if (!rst_n) begin
      cur_row = 0;
      cur_col = 0;
      ink = tcw_pkg::COLOR_RESET;
      due_results.delete();
    end else begin
      if (cfg_we) ink = cfg_wdata;
      if (out_valid && !out_stall) begin
        checked++;
        if (due_results.size() == 0) begin
          if (fails < 10) begin
            $display("result %0d arrived with no transaction waiting:", checked);
            $display("  got row %0d col %0d char %h color %h scrolled %0b",
                     out_data.cursor_row_out, out_data.cursor_col_out,
                     out_data.cell_char, out_data.cell_color, out_data.scrolled);
          end
          fails++;
        end else begin
          want = due_results.pop_front();
          if (want !== out_data) begin
            if (fails < 10) begin
              $display("result %0d mismatch:", checked);
              $display("  expected row %0d col %0d char %h color %h scrolled %0b",
                       want.cursor_row_out, want.cursor_col_out,
                       want.cell_char, want.cell_color, want.scrolled);
              $display("  got row %0d col %0d char %h color %h scrolled %0b",
                       out_data.cursor_row_out, out_data.cursor_col_out,
                       out_data.cell_char, out_data.cell_color, out_data.scrolled);
            end
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = console_step(in_data);
        if (want.scrolled) scrolls++;
        due_results.push_back(want);
      end
    end
    n_pending <= due_results.size();
    n_results <= checked;
    n_scrolls <= scrolls;
    n_fail    <= fails;
  end

endmodule

>>> test/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
module tb_text_console_writer_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         STALL_PCT = 23;
  localparam int         IDLE_LIMIT = 50000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tcw_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tcw_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;

  bit calm;
  int n_pending;
  int n_results;
  int n_scrolls;
  int n_fail;
  int n_sent;
  int n_clears;
  int n_reads;
  int n_colors;
  int idle_cycles;

  text_console_writer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  text_console_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .n_pending (n_pending),
    .n_results (n_results),
    .n_scrolls (n_scrolls),
    .n_fail    (n_fail)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
  end

  function automatic tcw_pkg::in_item_t any_item(input logic [1:0] op);
    tcw_pkg::in_item_t it;
    it.opcode    = op;
    it.char_code = 8'($urandom_range(255));
    it.read_row  = 5'($urandom_range(31));
    it.read_col  = 7'($urandom_range(127));
    return it;
  endfunction

  function automatic tcw_pkg::in_item_t random_txn();
    tcw_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(999);
    if (pick < 6) begin
      it = any_item(tcw_pkg::OP_CLEAR);
    end else if (pick < 26) begin
      it = any_item(OP_UNUSED);
    end else if (pick < 206) begin
      it = any_item(tcw_pkg::OP_READ);
      if ($urandom_range(99) < 85) begin
        it.read_row = 5'($urandom_range(tcw_pkg::ROWS_DEF - 1));
        it.read_col = 7'($urandom_range(tcw_pkg::COLUMNS_DEF - 1));
      end
    end else begin
      it = any_item(tcw_pkg::OP_PUT);
      pick = $urandom_range(99);
      if (pick < 12) begin
        it.char_code = tcw_pkg::CH_NEWLINE;
      end else if (pick < 15) begin
        it.char_code = tcw_pkg::CH_RETURN;
      end else if (pick < 21) begin
        it.char_code = tcw_pkg::CH_BACKSPACE;
      end
    end
    return it;
  endfunction

  task automatic send_txn(input tcw_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (it.opcode == tcw_pkg::OP_CLEAR) n_clears++;
    if (it.opcode == tcw_pkg::OP_READ) n_reads++;
  endtask

  task automatic put(input logic [7:0] ch);
    tcw_pkg::in_item_t it;
    it = any_item(tcw_pkg::OP_PUT);
    it.char_code = ch;
    send_txn(it);
  endtask

  task automatic read_at(input logic [4:0] row, input logic [6:0] col);
    tcw_pkg::in_item_t it;
    it = any_item(tcw_pkg::OP_READ);
    it.read_row = row;
    it.read_col = col;
    send_txn(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_color(input logic [7:0] color);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_colors++;
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timed out after %0d cycles with no transaction.", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k;
    int phase;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The cell store holds garbage until the first clear, so clear comes first.
    send_txn(any_item(tcw_pkg::OP_CLEAR));
    read_at(5'd0, 7'd0);
    read_at(5'd24, 7'd79);
    settle();
    set_color(8'hFF);
    put(8'h00);
    put(8'hFF);
    put(8'h41);
    read_at(5'd0, 7'd0);
    read_at(5'd0, 7'd2);
    put(tcw_pkg::CH_BACKSPACE);
    read_at(5'd0, 7'd2);
    put(tcw_pkg::CH_BACKSPACE);
    put(tcw_pkg::CH_BACKSPACE);
    put(tcw_pkg::CH_BACKSPACE);
    put(8'h7E);
    put(tcw_pkg::CH_RETURN);
    read_at(5'd31, 7'd0);
    read_at(5'd0, 7'd127);
    read_at(5'd25, 7'd80);
    send_txn(any_item(OP_UNUSED));
    settle();
    set_color(8'h00);
    send_txn(any_item(tcw_pkg::OP_CLEAR));
    read_at(5'd12, 7'd40);
    // The last newline here lands on the bottom row and scrolls.
    for (k = 0; k < tcw_pkg::ROWS_DEF; k++) put(tcw_pkg::CH_NEWLINE);
    read_at(5'd24, 7'd0);
    read_at(5'd23, 7'd0);

    for (phase = 0; phase < 5; phase++) begin
      settle();
      calm = (phase == 2);
      unique case (phase)
        1:       set_color(8'hFF);
        3:       set_color(8'h00);
        default: set_color(8'($urandom_range(255)));
      endcase
      for (k = 0; k < 130; k++) begin
        if (phase == 3 && k == 65) settle();
        send_txn(random_txn());
      end
    end
    settle();

    $display("Sent %0d transactions, %0d clears and %0d reads, under %0d color settings.",
             n_sent, n_clears, n_reads, n_colors);
    $display("Checked %0d results, %0d of which scrolled the screen.", n_results, n_scrolls);
    if (n_fail == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
